// File: rtl/ats_pkg.sv
package ats_pkg;

  localparam int unsigned NumW     = 40;
  localparam int unsigned DenW     = 13;
  localparam int unsigned DivDepth = NumW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [12:0] MaxXferBytes = 13'd4096;
  localparam logic [12:0] BpsMin       = 13'd2;
  localparam logic [12:0] BpsMax       = 13'd4096;
  localparam logic [4:0]  HeadMax      = 5'd16;

  localparam logic [CfgIdxW-1:0] RegBps    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpt    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHeads  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLba    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDrive  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOnline = 3'd5;

  localparam logic [1:0] StIssued  = 2'd0;
  localparam logic [1:0] StNothing = 2'd1;
  localparam logic [1:0] StOffline = 2'd2;

  localparam logic [7:0] CmdRead  = 8'h20;
  localparam logic [7:0] CmdWrite = 8'h30;
  localparam logic [7:0] DevBase  = 8'hA0;

  typedef struct packed {
    logic [31:0] part_start;
    logic [31:0] part_end;
    logic [31:0] blk;
    logic [11:0] cnt;
    logic [7:0]  sec;
    logic        none;
    logic        wr;
  } side_t;

endpackage

// File: rtl/ats_if.sv
interface ats_req_if;
  logic        valid;
  logic        ready;
  logic [39:0] byte_offset;
  logic [30:0] byte_length;
  logic [31:0] part_start;
  logic [31:0] part_end;
  logic        is_write;

  modport source (output valid, byte_offset, byte_length, part_start, part_end, is_write,
                  input ready);
  modport sink   (input valid, byte_offset, byte_length, part_start, part_end, is_write,
                  output ready);
endinterface

interface ats_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] logical_block;
  logic [11:0] sector_total;
  logic [7:0]  count_reg;
  logic [7:0]  sector_reg;
  logic [7:0]  cyl_low_reg;
  logic [7:0]  cyl_high_reg;
  logic [7:0]  drive_head_reg;
  logic [7:0]  command_reg;

  modport source (output valid, status, logical_block, sector_total, count_reg, sector_reg,
                  cyl_low_reg, cyl_high_reg, drive_head_reg, command_reg,
                  input ready);
  modport sink   (input valid, status, logical_block, sector_total, count_reg, sector_reg,
                  cyl_low_reg, cyl_high_reg, drive_head_reg, command_reg,
                  output ready);
endinterface

// File: rtl/ata_transfer_address_setup_top.sv
// ATA task-file setup pipeline: one request beat may enter every clock while
// the output is not stalled; it passes through an input register, two parallel
// 40-stage dividers for offset and length, two address stages, two 40-stage
// CHS split dividers and an output register; every divider is bit-per-stage.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Configuration registers are written through cfg_we_i and must only change
// while no request is in flight.
module ata_transfer_address_setup_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ats_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ats_pkg::CfgDataW-1:0]   cfg_data_i,
  ats_req_if.sink                        req,
  ats_rsp_if.source                      rsp
);

  logic [12:0] bps_q;
  logic [7:0]  spt_q;
  logic [4:0]  heads_q;
  logic        lba_q, drive_q, online_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q    <= 13'd512;
      spt_q    <= 8'd63;
      heads_q  <= 5'd16;
      lba_q    <= 1'b1;
      drive_q  <= 1'b0;
      online_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ats_pkg::RegBps:    bps_q    <= cfg_data_i;
        ats_pkg::RegSpt:    spt_q    <= cfg_data_i[7:0];
        ats_pkg::RegHeads:  heads_q  <= cfg_data_i[4:0];
        ats_pkg::RegLba:    lba_q    <= cfg_data_i[0];
        ats_pkg::RegDrive:  drive_q  <= cfg_data_i[0];
        ats_pkg::RegOnline: online_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [12:0] bps;
  logic [7:0]  spt;
  logic [4:0]  heads;
  assign bps   = (bps_q < ats_pkg::BpsMin) ? ats_pkg::BpsMin :
                 (bps_q > ats_pkg::BpsMax) ? ats_pkg::BpsMax : bps_q;
  assign spt   = (spt_q == 8'd0) ? 8'd1 : spt_q;
  assign heads = (heads_q == 5'd0) ? 5'd1 :
                 (heads_q > ats_pkg::HeadMax) ? ats_pkg::HeadMax : heads_q;

  logic adv;
  logic out_v_q;
  assign adv       = !out_v_q || rsp.ready;
  assign req.ready = adv;

  // input stage
  logic        s0_v_q;
  logic [39:0] s0_off_q;
  logic [12:0] s0_len_q;
  ats_pkg::side_t s0_side_q, s0_side_d;

  always_comb begin
    s0_side_d            = '0;
    s0_side_d.part_start = req.part_start;
    s0_side_d.part_end   = req.part_end;
    s0_side_d.wr         = req.is_write;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_off_q  <= req.byte_offset;
      s0_len_q  <= (req.byte_length > 31'(ats_pkg::MaxXferBytes)) ?
                   ats_pkg::MaxXferBytes : req.byte_length[12:0];
      s0_side_q <= s0_side_d;
    end
  end

  logic [12:0] len_up;
  assign len_up = 13'(s0_len_q + bps - 13'd1);

  // offset and length division
  logic        d1_v;
  logic [39:0] first;
  logic [39:0] cnt_quo;
  logic [12:0] rem_a, rem_b;
  ats_pkg::side_t d1_side;

  ats_div u_div_off (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s0_v_q),
    .num_i(s0_off_q), .den_i(bps), .side_i(s0_side_q),
    .valid_o(d1_v), .quo_o(first), .rem_o(rem_a), .side_o(d1_side)
  );

  ats_div u_div_len (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s0_v_q),
    .num_i({27'd0, len_up}), .den_i(bps), .side_i(s0_side_q),
    .valid_o(), .quo_o(cnt_quo), .rem_o(rem_b), .side_o()
  );

  // absolute block
  logic        s1_v_q;
  logic [40:0] s1_blk_q;
  logic [12:0] s1_cnt_q;
  ats_pkg::side_t s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_blk_q  <= {1'b0, first} + {9'd0, d1_side.part_start};
      s1_cnt_q  <= cnt_quo[12:0];
      s1_side_q <= d1_side;
    end
  end

  // range check and clipping
  logic        none;
  logic [41:0] blk_end;
  logic [31:0] room;
  logic [12:0] cnt_clip;
  ats_pkg::side_t s2_side_d, s2_side_q;
  logic        s2_v_q;

  assign none     = (s1_cnt_q == 13'd0) || (s1_blk_q >= {9'd0, s1_side_q.part_end});
  assign blk_end  = {1'b0, s1_blk_q} + {29'd0, s1_cnt_q};
  assign room     = s1_side_q.part_end - s1_blk_q[31:0];
  assign cnt_clip = (blk_end > {10'd0, s1_side_q.part_end}) ? room[12:0] : s1_cnt_q;

  always_comb begin
    s2_side_d      = s1_side_q;
    s2_side_d.blk  = s1_blk_q[31:0];
    s2_side_d.cnt  = cnt_clip[11:0];
    s2_side_d.none = none;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q <= s2_side_d;
    end
  end

  // chs split: block / spt, then / heads
  logic        d2_v, d3_v;
  logic [39:0] trk, cyl_q40;
  logic [12:0] sec_rem, head_rem;
  ats_pkg::side_t d2_side, d2_side_fix, d3_side;

  ats_div u_div_spt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s2_v_q),
    .num_i({8'd0, s2_side_q.blk}), .den_i({5'd0, spt}), .side_i(s2_side_q),
    .valid_o(d2_v), .quo_o(trk), .rem_o(sec_rem), .side_o(d2_side)
  );

  always_comb begin
    d2_side_fix     = d2_side;
    d2_side_fix.sec = 8'(sec_rem[7:0] + 8'd1);
  end

  ats_div u_div_head (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(d2_v),
    .num_i(trk), .den_i({8'd0, heads}), .side_i(d2_side_fix),
    .valid_o(d3_v), .quo_o(cyl_q40), .rem_o(head_rem), .side_o(d3_side)
  );

  // result assembly
  logic [7:0]  sec_b, cyl_lo, cyl_hi;
  logic [3:0]  head_n;
  logic [1:0]  status_d;
  logic        go;

  assign sec_b  = lba_q ? d3_side.blk[7:0]   : d3_side.sec;
  assign cyl_lo = lba_q ? d3_side.blk[15:8]  : cyl_q40[7:0];
  assign cyl_hi = lba_q ? d3_side.blk[23:16] : cyl_q40[15:8];
  assign head_n = lba_q ? d3_side.blk[27:24] : head_rem[3:0];
  assign status_d = !online_q ? ats_pkg::StOffline :
                    d3_side.none ? ats_pkg::StNothing : ats_pkg::StIssued;
  assign go = (status_d == ats_pkg::StIssued);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp.status         <= status_d;
      rsp.logical_block  <= go ? d3_side.blk : '0;
      rsp.sector_total   <= go ? d3_side.cnt : '0;
      rsp.count_reg      <= go ? d3_side.cnt[7:0] : '0;
      rsp.sector_reg     <= go ? sec_b : '0;
      rsp.cyl_low_reg    <= go ? cyl_lo : '0;
      rsp.cyl_high_reg   <= go ? cyl_hi : '0;
      rsp.drive_head_reg <= go ? (ats_pkg::DevBase | {1'b0, lba_q, 1'b0, drive_q, head_n})
                               : '0;
      rsp.command_reg    <= go ? (d3_side.wr ? ats_pkg::CmdWrite : ats_pkg::CmdRead) : '0;
    end
  end

  assign rsp.valid = out_v_q;

  a_issued_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ats_pkg::StIssued |-> rsp.sector_total != 12'd0)
    else $error("issued beat with zero sectors");

  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != ats_pkg::StIssued |->
      rsp.logical_block == 32'd0 && rsp.command_reg == 8'd0)
    else $error("refused beat carries task-file data");

  a_cmd_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ats_pkg::StIssued |->
      rsp.command_reg == ats_pkg::CmdRead || rsp.command_reg == ats_pkg::CmdWrite)
    else $error("bad command byte");

endmodule

// File: rtl/ats_div.sv
module ats_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ats_pkg::NumW-1:0]    num_i,
  input  logic [ats_pkg::DenW-1:0]    den_i,
  input  ats_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [ats_pkg::NumW-1:0]    quo_o,
  output logic [ats_pkg::DenW-1:0]    rem_o,
  output ats_pkg::side_t              side_o
);

  localparam int unsigned N = ats_pkg::DivDepth;
  localparam int unsigned W = ats_pkg::NumW;
  localparam int unsigned D = ats_pkg::DenW;

  logic [N-1:0] v_q;
  logic [W-1:0] n_q [N];
  logic [D-1:0] r_q [N];
  logic [D-1:0] d_q [N];
  ats_pkg::side_t s_q [N];

  logic [W-1:0] n_d [N];
  logic [D-1:0] r_d [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] n_prev;
    logic [D-1:0] r_prev;
    logic [D-1:0] d_prev;
    logic [D:0]   t;
    logic         ge;
    if (k == 0) begin : g_first
      assign n_prev = num_i;
      assign r_prev = '0;
      assign d_prev = den_i;
    end else begin : g_rest
      assign n_prev = n_q[k-1];
      assign r_prev = r_q[k-1];
      assign d_prev = d_q[k-1];
    end
    assign t      = {r_prev, n_prev[W-1]};
    assign ge     = t >= {1'b0, d_prev};
    assign r_d[k] = ge ? D'(t - {1'b0, d_prev}) : t[D-1:0];
    assign n_d[k] = {n_prev[W-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_d[k];
        r_q[k] <= r_d[k];
        d_q[k] <= d_prev;
        s_q[k] <= (k == 0) ? side_i : s_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = n_q[N-1];
  assign rem_o   = r_q[N-1];
  assign side_o  = s_q[N-1];

endmodule
